// ===== rtl/core/m3inv_pkg.sv =====
package m3inv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int DW   = DATA_WIDTH;
    // cofactor: difference of two DW x DW products
    localparam int CW   = 2 * DW + 1;
    // low part of a cofactor when it is split for the determinant multiplies
    localparam int LW   = CW - DW;
    // determinant: sum of three DW x CW products
    localparam int DETW = DW + CW + 2;
    localparam int CMW  = CW - 1;
    localparam int DMW  = DETW - 1;
    localparam int SHW  = DETW - LW;

    // rounding numerator |C| * 2^(2F+1) + |D|
    localparam int NUMA = CMW + 2 * FRAC_BITS + 1;
    localparam int NUMW = ((NUMA > DMW) ? NUMA : DMW) + 1;
    // divider remainder: holds the numerator and the divisor shifted by DW
    localparam int RW   = ((NUMW > DETW + DW) ? NUMW : DETW + DW) + 1;

    // divider stages: load, overflow test, then one quotient bit each
    localparam int NST  = DW + 2;

    localparam int QD   = 4;
    localparam int QAW  = $clog2(QD);

    // operands of each cofactor: C = a[P]*a[Q] - a[R]*a[S]
    localparam int CF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic signed [DW-1:0] a00;
        logic signed [DW-1:0] a01;
        logic signed [DW-1:0] a02;
        logic signed [DW-1:0] a10;
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a20;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a22;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] b00;
        logic signed [DW-1:0] b01;
        logic signed [DW-1:0] b02;
        logic signed [DW-1:0] b10;
        logic signed [DW-1:0] b11;
        logic signed [DW-1:0] b12;
        logic signed [DW-1:0] b20;
        logic signed [DW-1:0] b21;
        logic signed [DW-1:0] b22;
        logic                 singular;
    } t_out;

    typedef struct packed {
        logic [8:0][CMW-1:0] cmag;
        logic [8:0]          cneg;
        logic [DMW-1:0]      dmag;
        logic                dneg;
        logic                sing;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [8:0][RW-1:0] rem;
        logic [8:0][DW-1:0] q;
        logic [8:0]         ovf;
        logic [8:0]         cneg;
        logic [DETW-1:0]    den;
        logic               dneg;
        logic               sing;
    } t_dstage;

endpackage

// ===== rtl/core/m3inv_front.sv =====
module m3inv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  m3inv_pkg::t_in     i_data,
    output logic               o_stall,
    input  logic               i_full,
    output logic               o_push,
    output m3inv_pkg::t_qentry o_entry
);

    localparam int DW   = m3inv_pkg::DW;
    localparam int CW   = m3inv_pkg::CW;
    localparam int LW   = m3inv_pkg::LW;
    localparam int DETW = m3inv_pkg::DETW;
    localparam int SHW  = m3inv_pkg::SHW;
    localparam int CMW  = m3inv_pkg::CMW;
    localparam int DMW  = m3inv_pkg::DMW;

    logic signed [DW-1:0] a [9];
    logic                 f_en;
    logic [4:0]           r_v;

    logic signed [2*DW-1:0]    r_pa [9];
    logic signed [2*DW-1:0]    r_pb [9];
    logic signed [DW-1:0]      r_a1 [3];
    logic signed [DW-1:0]      r_a2 [3];
    logic signed [CW-1:0]      r_cof2 [9];
    logic signed [CW-1:0]      r_cof3 [9];
    logic signed [CW-1:0]      r_cof4 [9];
    logic signed [CW-1:0]      r_cof5 [9];
    logic signed [DW+LW:0]     r_pl [3];
    logic signed [2*DW-1:0]    r_ph [3];
    logic signed [DETW-1:0]    r_sl;
    logic signed [SHW-1:0]     r_sh;
    logic signed [DETW-1:0]    r_det;
    logic signed [CW-1:0]      n_cabs [9];
    logic signed [DETW-1:0]    n_dabs;

    assign a[0] = i_data.a00;
    assign a[1] = i_data.a01;
    assign a[2] = i_data.a02;
    assign a[3] = i_data.a10;
    assign a[4] = i_data.a11;
    assign a[5] = i_data.a12;
    assign a[6] = i_data.a20;
    assign a[7] = i_data.a21;
    assign a[8] = i_data.a22;

    // hold the whole front while its last stage waits on a full queue
    assign f_en    = !(r_v[4] && i_full);
    assign o_stall = !f_en;
    assign o_push  = r_v[4] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (f_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (f_en) begin
                r_pa[k]   <= a[m3inv_pkg::CF_P[k]] * a[m3inv_pkg::CF_Q[k]];
                r_pb[k]   <= a[m3inv_pkg::CF_R[k]] * a[m3inv_pkg::CF_S[k]];
                r_cof2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
                r_cof3[k] <= r_cof2[k];
                r_cof4[k] <= r_cof3[k];
                r_cof5[k] <= r_cof4[k];
            end
        end
        assign n_cabs[k]          = r_cof5[k][CW-1] ? -r_cof5[k] : r_cof5[k];
        assign o_entry.cmag[k]    = n_cabs[k][CMW-1:0];
        assign o_entry.cneg[k]    = r_cof5[k][CW-1];
    end

    // first-row expansion: a0*c0 + a1*c3 + a2*c6, each cofactor split in two
    for (genvar i = 0; i < 3; i++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (f_en) begin
                r_a1[i] <= a[i];
                r_a2[i] <= r_a1[i];
                r_pl[i] <= r_a2[i] * $signed({1'b0, r_cof2[3*i][LW-1:0]});
                r_ph[i] <= r_a2[i] * $signed(r_cof2[3*i][CW-1:LW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_sl  <= DETW'(r_pl[0]) + DETW'(r_pl[1]) + DETW'(r_pl[2]);
            r_sh  <= SHW'(r_ph[0]) + SHW'(r_ph[1]) + SHW'(r_ph[2]);
            r_det <= $signed({r_sh, {LW{1'b0}}}) + r_sl;
        end
    end

    assign n_dabs       = r_det[DETW-1] ? -r_det : r_det;
    assign o_entry.dmag = n_dabs[DMW-1:0];
    assign o_entry.dneg = r_det[DETW-1];
    assign o_entry.sing = (r_det == '0);

endmodule

// ===== rtl/core/m3inv_queue.sv =====
module m3inv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  m3inv_pkg::t_qentry i_entry,
    input  logic               i_pop,
    output m3inv_pkg::t_qentry o_entry,
    output m3inv_pkg::t_qstat  o_stat
);

    localparam int QD  = m3inv_pkg::QD;
    localparam int QAW = m3inv_pkg::QAW;

    m3inv_pkg::t_qentry r_mem [QD];
    logic [QAW-1:0]     r_wp;
    logic [QAW-1:0]     r_rp;
    logic [QAW:0]       r_cnt;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QD));
    assign o_stat.empty = (r_cnt == '0);
    assign o_entry      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/m3inv_back.sv =====
module m3inv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  m3inv_pkg::t_qentry i_entry,
    input  m3inv_pkg::t_qstat  i_qstat,
    output logic               o_pop,
    output logic               o_valid,
    output m3inv_pkg::t_out    o_data,
    input  logic               i_stall
);

    localparam int DW   = m3inv_pkg::DW;
    localparam int RW   = m3inv_pkg::RW;
    localparam int NUMW = m3inv_pkg::NUMW;
    localparam int DETW = m3inv_pkg::DETW;
    localparam int NST  = m3inv_pkg::NST;
    localparam int FB   = m3inv_pkg::FRAC_BITS;

    logic                b_en;
    logic [NST-1:0]      r_dv;
    m3inv_pkg::t_dstage  r_ds [NST];
    m3inv_pkg::t_dstage  n_ds [NST];
    logic                r_out_valid;
    m3inv_pkg::t_out     r_out;
    logic [DW-1:0]       n_b [9];
    logic [DW-1:0]       lim;

    // advance the divider whenever the output register is free or drains
    assign b_en  = !r_out_valid || !i_stall;
    assign o_pop = b_en && !i_qstat.empty;

    // load: numerator with the half-divisor rounding term, divisor 2|D|
    always_comb begin
        n_ds[0]      = '0;
        n_ds[0].den  = DETW'({i_entry.dmag, 1'b0});
        n_ds[0].dneg = i_entry.dneg;
        n_ds[0].sing = i_entry.sing;
        n_ds[0].cneg = i_entry.cneg;
        for (int l = 0; l < 9; l++) begin
            n_ds[0].rem[l] = RW'((NUMW'(i_entry.cmag[l]) << (2 * FB + 1))
                                 + NUMW'(i_entry.dmag));
        end
    end

    for (genvar j = 1; j < NST; j++) begin : g_step
        localparam int SH = DW + 1 - j;
        logic [RW-1:0] w_d;
        assign w_d = RW'(r_ds[j-1].den) << SH;
        if (j == 1) begin : g_ovf
            // quotient of 2^DW or more saturates either way
            always_comb begin
                n_ds[j] = r_ds[j-1];
                for (int l = 0; l < 9; l++) begin
                    n_ds[j].ovf[l] = (r_ds[j-1].rem[l] >= w_d);
                end
            end
        end else begin : g_bit
            always_comb begin
                n_ds[j] = r_ds[j-1];
                for (int l = 0; l < 9; l++) begin
                    if (r_ds[j-1].rem[l] >= w_d) begin
                        n_ds[j].rem[l]   = r_ds[j-1].rem[l] - w_d;
                        n_ds[j].q[l][SH] = 1'b1;
                    end
                end
            end
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_ds[j] <= n_ds[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (b_en) begin
            r_dv <= {r_dv[NST-2:0], !i_qstat.empty};
        end
    end

    assign lim = DW'(1) << (DW - 1);

    always_comb begin
        for (int l = 0; l < 9; l++) begin
            if (r_ds[NST-1].sing) begin
                n_b[l] = '0;
            end else if (r_ds[NST-1].cneg[l] != r_ds[NST-1].dneg) begin
                if (r_ds[NST-1].ovf[l] || r_ds[NST-1].q[l] > lim) begin
                    n_b[l] = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    n_b[l] = -r_ds[NST-1].q[l];
                end
            end else begin
                if (r_ds[NST-1].ovf[l] || r_ds[NST-1].q[l] >= lim) begin
                    n_b[l] = {1'b0, {(DW-1){1'b1}}};
                end else begin
                    n_b[l] = r_ds[NST-1].q[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_out_valid <= r_dv[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_out.b00      <= n_b[0];
            r_out.b01      <= n_b[1];
            r_out.b02      <= n_b[2];
            r_out.b10      <= n_b[3];
            r_out.b11      <= n_b[4];
            r_out.b12      <= n_b[5];
            r_out.b20      <= n_b[6];
            r_out.b21      <= n_b[7];
            r_out.b22      <= n_b[8];
            r_out.singular <= r_ds[NST-1].sing;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/matrix3_inverse.sv =====
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// Path: 5 front stages, queue memory, DATA_WIDTH+2 divider stages, output reg.
// Throughput: one matrix per cycle while o_stall and i_stall stay low; the
// 9-lane divider retires one quotient bit per stage, and the 4-entry queue
// lets front and back stall apart.
// Reset: synchronous, active low; clears all valid bits and queue pointers.
module matrix3_inverse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  m3inv_pkg::t_in  i_data,
    output logic            o_stall,
    output logic            o_valid,
    output m3inv_pkg::t_out o_data,
    input  logic            i_stall
);

    logic               push;
    logic               pop;
    m3inv_pkg::t_qentry f_entry;
    m3inv_pkg::t_qentry q_entry;
    m3inv_pkg::t_qstat  q_stat;

    // front: cofactors, determinant, sign/magnitude split and singular test
    m3inv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (q_stat.full),
        .o_push  (push),
        .o_entry (f_entry)
    );

    // queue: decouple the front from output back-pressure
    m3inv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_stat  (q_stat)
    );

    // back: nine restoring dividers in lockstep, round, saturate, drive beat
    m3inv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_entry),
        .i_qstat (q_stat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// ===== rtl/core/m3inv_checker.sv =====
module m3inv_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input m3inv_pkg::t_in  i_data,
    input logic            o_stall,
    input logic            o_valid,
    input m3inv_pkg::t_out o_data,
    input logic            i_stall
);

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat valid straight after reset");

    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled straight after reset");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |->
            (o_data.b00 == '0 && o_data.b01 == '0 && o_data.b02 == '0 &&
             o_data.b10 == '0 && o_data.b11 == '0 && o_data.b12 == '0 &&
             o_data.b20 == '0 && o_data.b21 == '0 && o_data.b22 == '0))
        else $error("singular beat carries non-zero elements");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output beat changed");

endmodule

bind matrix3_inverse m3inv_checker u_m3inv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
